FILE: src/lnds_pkg.sv
// Shared types and constants for the longest non-decreasing subsequence unit.
package lnds_pkg;

  localparam int VALUE_W       = 11;
  localparam int LEN_W         = 16;
  localparam int EPOCH_W       = 8;
  localparam int VALUE_MAX_DEF = 1024;

  localparam logic [LEN_W-1:0] LEN_CAP = {LEN_W{1'b1}};

  // Input item
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               start_req;
  } in_t;

  // Result item
  typedef struct packed {
    logic [LEN_W-1:0] ending_length;
    logic [LEN_W-1:0] best_length;
  } out_t;

  // Tree entry: stored length tagged with the sequence epoch that wrote it
  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [LEN_W-1:0]   len;
  } entry_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_QUERY,
    S_LEN,
    S_UPD,
    S_OUT
  } state_t;

endpackage

FILE: src/longest_nondecreasing_subseq_unit.sv
// Longest non-decreasing subsequence unit: top level with output register.
//
// Usage: each input transfer on in_valid/in_stall carries one element value
// (1..VALUE_MAX, larger values clamp to VALUE_MAX, zero queries nothing) and
// a start flag that begins a new sequence. For each element one result
// transfer on out_valid/out_stall gives the longest non-decreasing
// subsequence ending at that element and the running best of the sequence,
// both saturating at 65535.
// The query walk reads popcount(v) tree nodes and the update walk reads P,
// v being the clamped value and P the number of tree nodes on its update
// path (at most log2(VALUE_MAX)+1). One element at a time: in_stall stays
// high from the input transfer until the result is handed to the output
// register. The start flag bumps an 8-bit epoch instead of clearing the tree;
// every 256th start the epoch wraps and a clearing pass over all VALUE_MAX
// entries runs before that element. After reset the same pass runs with
// in_stall high. The result sits in an output register; while the receiver
// stalls, the next element is still taken and processed, and waits only
// for the register to empty. The tree memory has one read port, walked one
// node per cycle.
module longest_nondecreasing_subseq_unit #(
  parameter int VALUE_MAX = lnds_pkg::VALUE_MAX_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  lnds_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output lnds_pkg::out_t  out_data
);
  import lnds_pkg::*;

  localparam int AW = $clog2(VALUE_MAX);

  logic          res_valid;
  logic          res_ready;
  out_t          res_data;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  entry_t        mem_rd_data;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  entry_t        mem_wr_data;

  lnds_ctrl #(
    .VALUE_MAX (VALUE_MAX),
    .AW        (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_data    (res_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  lnds_tree_mem #(
    .VALUE_MAX (VALUE_MAX),
    .AW        (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  // Output register is free when empty or being drained this cycle
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data <= res_data;
    end
  end

endmodule

FILE: src/lnds_tree_mem.sv
// Single-port-read, single-port-write memory holding the prefix-max tree.
module lnds_tree_mem #(
  parameter int VALUE_MAX = lnds_pkg::VALUE_MAX_DEF,
  parameter int AW        = $clog2(VALUE_MAX)
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output lnds_pkg::entry_t     rd_data,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  lnds_pkg::entry_t     wr_data
);
  import lnds_pkg::*;

  entry_t mem [VALUE_MAX];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/lnds_ctrl.sv
// Sequencer: epoch handling, prefix-max query walk and update walk over the tree.
module lnds_ctrl #(
  parameter int VALUE_MAX = lnds_pkg::VALUE_MAX_DEF,
  parameter int AW        = $clog2(VALUE_MAX)
) (
  input  logic              clk,
  input  logic              rst,
  // input side
  input  logic              in_valid,
  output logic              in_stall,
  input  lnds_pkg::in_t     in_data,
  // result towards output register
  output logic              res_valid,
  input  logic              res_ready,
  output lnds_pkg::out_t    res_data,
  // tree memory
  output logic              mem_rd_en,
  output logic [AW-1:0]     mem_rd_addr,
  input  lnds_pkg::entry_t  mem_rd_data,
  output logic              mem_wr_en,
  output logic [AW-1:0]     mem_wr_addr,
  output lnds_pkg::entry_t  mem_wr_data
);
  import lnds_pkg::*;

  localparam int IW = $clog2(VALUE_MAX + 1);
  localparam int UW = IW + 1;
  localparam int CW = (IW > VALUE_W) ? IW : VALUE_W;

  localparam logic [CW-1:0] VMAX_C  = CW'(VALUE_MAX);
  localparam logic [IW-1:0] VMAX_I  = IW'(VALUE_MAX);
  localparam logic [UW-1:0] VMAX_U  = UW'(VALUE_MAX);
  localparam logic [AW-1:0] LAST_A  = AW'(VALUE_MAX - 1);

  state_t             state, state_next;
  logic [EPOCH_W-1:0] epoch, epoch_next;
  logic [LEN_W-1:0]   best, best_next;
  logic [LEN_W-1:0]   acc, acc_next;
  logic [LEN_W-1:0]   len, len_next;
  logic [IW-1:0]      idx, idx_next;
  logic [IW-1:0]      qidx, qidx_next;
  logic [UW-1:0]      uidx, uidx_next;
  logic               pend, pend_next;
  logic [AW-1:0]      pend_addr, pend_addr_next;
  logic [AW-1:0]      clr_addr, clr_addr_next;
  logic               clr_query, clr_query_next;

  logic [CW-1:0]      val_c;
  logic [IW-1:0]      idx_in;
  logic [LEN_W-1:0]   stored;
  logic [LEN_W-1:0]   len_c;
  logic               upd_active;

  // Clamp the incoming value to the tree size
  assign val_c  = CW'(in_data.value);
  assign idx_in = (val_c > VMAX_C) ? VMAX_I : IW'(val_c);

  // An entry written in an older epoch reads as zero
  assign stored = (mem_rd_data.tag == epoch) ? mem_rd_data.len : '0;

  // Saturating increment of the query result
  assign len_c = (acc == LEN_CAP) ? LEN_CAP : acc + LEN_W'(1);

  assign upd_active = (uidx != '0) && (uidx <= VMAX_U);

  assign in_stall  = (state != S_IDLE);
  assign res_valid = (state == S_OUT);
  assign res_data  = '{ending_length: len, best_length: best};

  // Next state, walk steps and memory controls
  always_comb begin
    state_next     = state;
    epoch_next     = epoch;
    best_next      = best;
    acc_next       = acc;
    len_next       = len;
    idx_next       = idx;
    qidx_next      = qidx;
    uidx_next      = uidx;
    pend_next      = 1'b0;
    pend_addr_next = pend_addr;
    clr_addr_next  = clr_addr;
    clr_query_next = clr_query;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = '0;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = clr_addr;
    mem_wr_data    = '0;

    unique case (state)
      S_CLR: begin
        mem_wr_en     = 1'b1;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == LAST_A) begin
          state_next = clr_query ? S_QUERY : S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          idx_next  = idx_in;
          qidx_next = idx_in;
          acc_next  = '0;
          if (in_data.start_req) begin
            best_next  = '0;
            epoch_next = epoch + EPOCH_W'(1);
          end
          // Epoch wrap: old tags would alias, so sweep the tree first
          if (in_data.start_req && (epoch_next == '0)) begin
            clr_addr_next  = '0;
            clr_query_next = 1'b1;
            state_next     = S_CLR;
          end else begin
            state_next = S_QUERY;
          end
        end
      end

      S_QUERY: begin
        // Addresses do not depend on data: one read per cycle
        if (qidx != '0) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = AW'(qidx - IW'(1));
          qidx_next   = qidx - (qidx & (~qidx + IW'(1)));
          pend_next   = 1'b1;
        end else begin
          state_next = S_LEN;
        end
        if (pend && (stored > acc)) begin
          acc_next = stored;
        end
      end

      S_LEN: begin
        len_next   = len_c;
        best_next  = (len_c > best) ? len_c : best;
        uidx_next  = UW'(idx);
        state_next = S_UPD;
      end

      S_UPD: begin
        // Read ahead on the update path, write back in the following cycle
        if (upd_active) begin
          mem_rd_en      = 1'b1;
          mem_rd_addr    = AW'(uidx - UW'(1));
          pend_next      = 1'b1;
          pend_addr_next = AW'(uidx - UW'(1));
          uidx_next      = uidx + (uidx & (~uidx + UW'(1)));
        end else begin
          state_next = S_OUT;
        end
        if (pend && (stored < len)) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = pend_addr;
          mem_wr_data = '{tag: epoch, len: len};
        end
      end

      S_OUT: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      epoch     <= '0;
      best      <= '0;
      pend      <= 1'b0;
      clr_addr  <= '0;
      clr_query <= 1'b0;
    end else begin
      state     <= state_next;
      epoch     <= epoch_next;
      best      <= best_next;
      pend      <= pend_next;
      clr_addr  <= clr_addr_next;
      clr_query <= clr_query_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    acc       <= acc_next;
    len       <= len_next;
    idx       <= idx_next;
    qidx      <= qidx_next;
    uidx      <= uidx_next;
    pend_addr <= pend_addr_next;
  end

  // Write-back never targets the entry being read ahead
  assert property (@(posedge clk) disable iff (rst)
    (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
    else $error("tree read and write hit the same entry");

  // A finished result is at least one and never above the running best
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((len != '0) && (best >= len)))
    else $error("result lengths inconsistent");

  // No read left in flight once the update walk ends
  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> !pend)
    else $error("pending read at result");

  // The query walk always hands over to the length step
  assert property (@(posedge clk) disable iff (rst)
    ((state == S_QUERY) && (qidx == '0)) |=> (state == S_LEN))
    else $error("query walk did not finish");

endmodule
